// ===== rtl/rgbds_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package rgbds_pkg;

  // fixed field widths
  localparam int COL_W      = 12;
  localparam int CH_W       = 8;
  localparam int CHANNELS   = 3;
  localparam int SUM_W      = 10;
  localparam int SCALE_LOG2 = 2;
  localparam int SCALE      = 1 << SCALE_LOG2;
  localparam int PIX_W      = CHANNELS * CH_W;

  localparam logic [COL_W-1:0] WIDTH_RESET = 12'd640;

  // channel slots inside a pixel word
  localparam int CH_RED   = 0;
  localparam int CH_GREEN = 1;
  localparam int CH_BLUE  = 2;

  typedef enum logic [1:0] {
    ROW_FIRST,
    ROW_SECOND,
    ROW_THIRD,
    ROW_FOURTH
  } row_phase_e;

  typedef logic [CHANNELS-1:0][CH_W-1:0] pixel_t;

  // control of the item in the modify stage
  typedef struct packed {
    logic       valid;
    row_phase_e phase;
    logic       in_tile;
    logic       tile_first;
    logic       emit;
    logic       line_end;
  } stage_ctl_t;

  typedef struct packed {
    pixel_t pix;
    logic   line_end;
  } result_t;

  // rounding average of two channel values
  function automatic logic [CH_W-1:0] round_avg(input logic [CH_W-1:0] a,
                                                input logic [CH_W-1:0] b);
    logic [CH_W:0] s;
    s = {1'b0, a} + {1'b0, b} + {{CH_W{1'b0}}, 1'b1};
    return s[CH_W:1];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/rgbds_line_store.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rgbds_line_store #(
  parameter int DEPTH  = 2048,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  wire                       rd_en_i,
  input  wire [ADDR_W-1:0]          rd_addr_i,
  output rgbds_pkg::pixel_t         rd_data_o,
  input  wire                       wr_en_i,
  input  wire [ADDR_W-1:0]          wr_addr_i,
  input  rgbds_pkg::pixel_t         wr_data_i
);
  import rgbds_pkg::*;

  pixel_t mem [DEPTH];
  pixel_t rd_data_q;
  pixel_t fwd_data_q;
  logic   fwd_q;

  // storage array, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q  <= mem[rd_addr_i];
      fwd_data_q <= wr_data_i;
    end
  end

  // bypass flag when a read hits the entry written in the same cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else if (rd_en_i) begin
      fwd_q <= wr_en_i && (wr_addr_i == rd_addr_i);
    end
  end

  assign rd_data_o = fwd_q ? fwd_data_q : rd_data_q;

endmodule

`default_nettype wire

// ===== rtl/rgbds_tile_calc.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rgbds_tile_calc (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  rgbds_pkg::stage_ctl_t    ctl_i,
  input  rgbds_pkg::pixel_t        pix_i,
  input  rgbds_pkg::pixel_t        upper_rd_i,
  input  rgbds_pkg::pixel_t        third_rd_i,
  output logic                     upper_we_o,
  output rgbds_pkg::pixel_t        upper_wd_o,
  output logic                     third_we_o,
  output rgbds_pkg::pixel_t        third_wd_o,
  output logic                     push_o,
  output rgbds_pkg::result_t       push_data_o
);
  import rgbds_pkg::*;

  logic [CHANNELS-1:0][SUM_W-1:0] sums_q, sums_d;
  logic [CHANNELS-1:0][CH_W-1:0]  lower, vert;
  logic                           active, acc_en;

  assign active = ctl_i.valid && ctl_i.in_tile;
  assign acc_en = active && (ctl_i.phase == ROW_FOURTH);

  // vertical averages, horizontal running sums and write-back data
  always_comb begin
    for (int c = 0; c < CHANNELS; c++) begin
      lower[c]  = round_avg(third_rd_i[c], pix_i[c]);
      vert[c]   = round_avg(upper_rd_i[c], lower[c]);
      sums_d[c] = (ctl_i.tile_first ? {SUM_W{1'b0}} : sums_q[c])
                  + {{(SUM_W-CH_W){1'b0}}, vert[c]};
      upper_wd_o[c] = (ctl_i.phase == ROW_FIRST) ? pix_i[c]
                                                 : round_avg(upper_rd_i[c], pix_i[c]);
      push_data_o.pix[c] = sums_d[c][SCALE_LOG2 +: CH_W];
    end
    third_wd_o           = pix_i;
    push_data_o.line_end = ctl_i.line_end;
    upper_we_o = active && ((ctl_i.phase == ROW_FIRST) || (ctl_i.phase == ROW_SECOND));
    third_we_o = active && (ctl_i.phase == ROW_THIRD);
    push_o     = active && ctl_i.emit;
  end

  // channel sums of the current tile
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sums_q <= '0;
    end else if (acc_en) begin
      sums_q <= sums_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/rgbds_out_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rgbds_out_fifo (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire                      push_i,
  input  rgbds_pkg::result_t       push_data_i,
  input  wire                      pop_i,
  output logic                     valid_o,
  output rgbds_pkg::result_t       data_o,
  output logic [1:0]               count_o
);
  import rgbds_pkg::*;

  result_t    slot_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       do_pop;

  assign do_pop  = pop_i && (count_q != 2'd0);
  assign valid_o = (count_q != 2'd0);
  assign data_o  = slot_q[rd_ptr_q];
  assign count_o = count_q;

  // result slots
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      count_q <= count_q + {1'b0, push_i} - {1'b0, do_pop};
    end
  end

endmodule

`default_nettype wire

// ===== rtl/rgb_box_downscale_by_four.sv =====
`timescale 1ns / 1ps
`default_nettype none

// channel   | direction | handshake                 | payload
// ----------+-----------+---------------------------+------------------------------------------
// pixel in  | input     | in_valid_i / in_ready_o   | red_in_i green_in_i blue_in_i frame_start_i
// tile out  | output    | out_valid_o / out_ready_i | red_out_o green_out_o blue_out_o line_end_o
// config    | input     | line_width_we_i           | line_width_i
//
// one pixel item is taken per cycle while in_ready_o is high; each passes a read stage
// and a modify and write-back stage on the two line stores, and a tile result is
// registered into the output queue from the modify stage.
// reset clears counters, row phase and sums; the line stores hold no reset value.
// in_ready_o drops while the output queue holds two results, or holds one while
// another is on its way in from the modify stage.

module rgb_box_downscale_by_four #(
  parameter int MAX_LINE_PIXELS = 2048
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         in_valid_i,
  output logic        in_ready_o,
  input  wire  [7:0]  red_in_i,
  input  wire  [7:0]  green_in_i,
  input  wire  [7:0]  blue_in_i,
  input  wire         frame_start_i,
  output logic        out_valid_o,
  input  wire         out_ready_i,
  output logic [7:0]  red_out_o,
  output logic [7:0]  green_out_o,
  output logic [7:0]  blue_out_o,
  output logic        line_end_o,
  input  wire         line_width_we_i,
  input  wire  [11:0] line_width_i
);
  import rgbds_pkg::*;

  localparam int ADDR_W = $clog2(MAX_LINE_PIXELS);
  localparam int EXT_W  = (ADDR_W > COL_W) ? ADDR_W : COL_W;

  logic [COL_W-1:0]  line_width_q;
  logic [COL_W-1:0]  col_q, col_d;
  row_phase_e        phase_q, phase_d;
  stage_ctl_t        s1_ctl_q, s1_ctl_d;
  pixel_t            s1_pix_q, in_pix;
  logic [ADDR_W-1:0] s1_addr_q, rd_addr;

  logic [COL_W-1:0]  w_eff, full_w, col_cur;
  logic [COL_W:0]    col_inc;
  logic [EXT_W-1:0]  col_ext;
  row_phase_e        phase_cur;
  logic              accept, line_done;

  pixel_t            upper_rd, third_rd, upper_wd, third_wd;
  logic              upper_we, third_we, push;
  result_t           push_data, out_data;
  logic [1:0]        fifo_cnt, pending;

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_width_q <= WIDTH_RESET;
    end else if (line_width_we_i) begin
      line_width_q <= line_width_i;
    end
  end

  // effective width and last full tile boundary
  always_comb begin
    w_eff = line_width_q;
    if (line_width_q < COL_W'(SCALE)) begin
      w_eff = COL_W'(SCALE);
    end else if (int'(line_width_q) > MAX_LINE_PIXELS) begin
      w_eff = COL_W'(MAX_LINE_PIXELS);
    end
    full_w = {w_eff[COL_W-1:SCALE_LOG2], {SCALE_LOG2{1'b0}}};
  end

  // input side: position of the item and its control
  assign in_pix[CH_RED]   = red_in_i;
  assign in_pix[CH_GREEN] = green_in_i;
  assign in_pix[CH_BLUE]  = blue_in_i;

  assign pending    = fifo_cnt + {1'b0, s1_ctl_q.valid && s1_ctl_q.emit};
  assign in_ready_o = (pending <= 2'd1);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    col_cur   = frame_start_i ? '0 : col_q;
    phase_cur = frame_start_i ? ROW_FIRST : phase_q;
    col_inc   = {1'b0, col_cur} + {{COL_W{1'b0}}, 1'b1};
    line_done = (col_inc >= {1'b0, w_eff});
    col_ext   = EXT_W'(col_cur);
    rd_addr   = col_ext[ADDR_W-1:0];

    s1_ctl_d.valid      = accept;
    s1_ctl_d.phase      = phase_cur;
    s1_ctl_d.in_tile    = (col_cur < full_w);
    s1_ctl_d.tile_first = (col_cur[SCALE_LOG2-1:0] == '0);
    s1_ctl_d.emit       = (col_cur < full_w) && (phase_cur == ROW_FOURTH)
                          && (&col_cur[SCALE_LOG2-1:0]);
    s1_ctl_d.line_end   = (col_inc == {1'b0, full_w});

    col_d   = col_q;
    phase_d = phase_q;
    if (accept) begin
      if (line_done) begin
        col_d   = '0;
        phase_d = row_phase_e'(2'(phase_cur) + 2'd1);
      end else begin
        col_d   = col_inc[COL_W-1:0];
        phase_d = phase_cur;
      end
    end
  end

  // column and row counters, stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q    <= '0;
      phase_q  <= ROW_FIRST;
      s1_ctl_q <= '0;
    end else begin
      col_q    <= col_d;
      phase_q  <= phase_d;
      s1_ctl_q <= s1_ctl_d;
    end
  end

  // stage payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_pix_q  <= in_pix;
      s1_addr_q <= rd_addr;
    end
  end

  // line stores
  rgbds_line_store #(
    .DEPTH  (MAX_LINE_PIXELS),
    .ADDR_W (ADDR_W)
  ) u_upper_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (accept),
    .rd_addr_i (rd_addr),
    .rd_data_o (upper_rd),
    .wr_en_i   (upper_we),
    .wr_addr_i (s1_addr_q),
    .wr_data_i (upper_wd)
  );

  rgbds_line_store #(
    .DEPTH  (MAX_LINE_PIXELS),
    .ADDR_W (ADDR_W)
  ) u_third_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (accept),
    .rd_addr_i (rd_addr),
    .rd_data_o (third_rd),
    .wr_en_i   (third_we),
    .wr_addr_i (s1_addr_q),
    .wr_data_i (third_wd)
  );

  // modify stage
  rgbds_tile_calc u_calc (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (s1_ctl_q),
    .pix_i       (s1_pix_q),
    .upper_rd_i  (upper_rd),
    .third_rd_i  (third_rd),
    .upper_we_o  (upper_we),
    .upper_wd_o  (upper_wd),
    .third_we_o  (third_we),
    .third_wd_o  (third_wd),
    .push_o      (push),
    .push_data_o (push_data)
  );

  // output queue
  rgbds_out_fifo u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (out_ready_i),
    .valid_o     (out_valid_o),
    .data_o      (out_data),
    .count_o     (fifo_cnt)
  );

  assign red_out_o   = out_data.pix[CH_RED];
  assign green_out_o = out_data.pix[CH_GREEN];
  assign blue_out_o  = out_data.pix[CH_BLUE];
  assign line_end_o  = out_data.line_end;

endmodule

`default_nettype wire

// ===== rtl/rgbds_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rgbds_checker (
  input wire       clk_i,
  input wire       rst_ni,
  input wire       in_valid_i,
  input wire       in_ready_o,
  input wire       out_valid_o,
  input wire       out_ready_i,
  input wire [7:0] red_out_o,
  input wire [7:0] green_out_o,
  input wire [7:0] blue_out_o,
  input wire       line_end_o
);

  // a result stays offered until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result item dropped before it was taken");

  // a stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable({red_out_o, green_out_o, blue_out_o, line_end_o}))
    else $error("stalled result item changed");

  // input back-pressure only while results are waiting
  a_ready_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled with no result waiting");

  // a fresh result follows an accepted pixel through the stage register and the queue
  a_out_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o, 2))
    else $error("result item without a matching pixel item");

endmodule

bind rgb_box_downscale_by_four rgbds_checker u_rgbds_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .red_out_o   (red_out_o),
  .green_out_o (green_out_o),
  .blue_out_o  (blue_out_o),
  .line_end_o  (line_end_o)
);

`default_nettype wire

// ===== verif/tb_rgb_box_downscale_by_four.sv =====
`timescale 1ns / 1ps

module tb_rgb_box_downscale_by_four;
  import rgbds_pkg::*;

  localparam int MAX_PIX      = 2048;
  localparam int RANDOM_ITEMS = 500;
  localparam int HOLD_CYCLES  = 300;
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_LIMIT  = 5000;
  localparam int MAX_REPORTS  = 10;
  localparam longint TIMEOUT_NS = 64'd8_000_000;

  // clock, reset and block pins
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        pix_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  pix_red = '0;
  logic [7:0]  pix_green = '0;
  logic [7:0]  pix_blue = '0;
  logic        pix_fs = 1'b0;
  logic        out_valid;
  logic        tile_ready = 1'b0;
  logic [7:0]  out_red;
  logic [7:0]  out_green;
  logic [7:0]  out_blue;
  logic        out_line_end;
  logic        width_we = 1'b0;
  logic [11:0] width_val = '0;

  // shared test state
  result_t     expected_tiles [$];
  int          err_count = 0;
  int          items_sent = 0;
  int          hold_reqs = 0;
  bit          steady = 1'b0;

  // downscaler model state
  pixel_t      upper_px [MAX_PIX];
  pixel_t      third_px [MAX_PIX];
  bit          upper_set [MAX_PIX];
  bit          third_set [MAX_PIX];
  row_phase_e  row_pos = ROW_FIRST;
  int unsigned col_pos = 0;
  logic [SUM_W-1:0] tile_sums [CHANNELS];
  logic [11:0] model_width = WIDTH_RESET;

  rgb_box_downscale_by_four #(
    .MAX_LINE_PIXELS(MAX_PIX)
  ) DUT (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (pix_valid),
    .in_ready_o     (in_ready),
    .red_in_i       (pix_red),
    .green_in_i     (pix_green),
    .blue_in_i      (pix_blue),
    .frame_start_i  (pix_fs),
    .out_valid_o    (out_valid),
    .out_ready_i    (tile_ready),
    .red_out_o      (out_red),
    .green_out_o    (out_green),
    .blue_out_o     (out_blue),
    .line_end_o     (out_line_end),
    .line_width_we_i(width_we),
    .line_width_i   (width_val)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // rounding mean of two channel values
  function automatic logic [CH_W-1:0] mean_up(input logic [CH_W-1:0] a,
                                              input logic [CH_W-1:0] b);
    logic [CH_W:0] s;
    s = {1'b0, a} + {1'b0, b} + 1'b1;
    return s[CH_W:1];
  endfunction

  // width clamped to the supported line range
  function automatic int unsigned eff_width(input logic [11:0] w);
    if (w < SCALE) return SCALE;
    if (w > MAX_PIX) return MAX_PIX;
    return 32'(w);
  endfunction

  function automatic pixel_t mk_pixel(input logic [7:0] r, input logic [7:0] g,
                                      input logic [7:0] b);
    pixel_t p;
    p[CH_RED]   = r;
    p[CH_GREEN] = g;
    p[CH_BLUE]  = b;
    return p;
  endfunction

  // random channels with extra weight on the extremes
  function automatic pixel_t rand_pixel();
    pixel_t p;
    int r;
    for (int c = 0; c < CHANNELS; c++) begin
      r = $urandom_range(9);
      p[c] = (r == 0) ? 8'd0 : (r == 1) ? 8'd255 : 8'($urandom_range(255));
    end
    return p;
  endfunction

  // true when the next item would read a line store entry never written
  function automatic bit reads_unset(input bit fs);
    row_phase_e  ph;
    int unsigned col, full;
    ph   = fs ? ROW_FIRST : row_pos;
    col  = fs ? 0 : col_pos;
    full = (eff_width(model_width) / SCALE) * SCALE;
    if (col >= full) return 1'b0;
    if (ph == ROW_SECOND) return !upper_set[col];
    if (ph == ROW_FOURTH) return !upper_set[col] || !third_set[col];
    return 1'b0;
  endfunction

  // advance the downscaler model by one accepted pixel
  task automatic advance_model(input pixel_t px, input bit fs);
    int unsigned w, full, col;
    logic [CH_W-1:0] lower, v;
    result_t tile;
    w    = eff_width(model_width);
    full = (w / SCALE) * SCALE;
    if (fs) begin
      row_pos = ROW_FIRST;
      col_pos = 0;
      for (int c = 0; c < CHANNELS; c++) tile_sums[c] = '0;
    end
    col = col_pos;
    if (col < full) begin
      if (col % SCALE == 0) begin
        for (int c = 0; c < CHANNELS; c++) tile_sums[c] = '0;
      end
      for (int c = 0; c < CHANNELS; c++) begin
        case (row_pos)
          ROW_FIRST: begin
            upper_px[col][c] = px[c];
            upper_set[col]   = 1'b1;
          end
          ROW_SECOND: begin
            upper_px[col][c] = mean_up(upper_px[col][c], px[c]);
          end
          ROW_THIRD: begin
            third_px[col][c] = px[c];
            third_set[col]   = 1'b1;
          end
          default: begin
            lower = mean_up(third_px[col][c], px[c]);
            v     = mean_up(upper_px[col][c], lower);
            tile_sums[c] = tile_sums[c] + {2'b00, v};
          end
        endcase
      end
      // last column of a tile on the fourth row gives one output pixel
      if (row_pos == ROW_FOURTH && col % SCALE == SCALE - 1) begin
        for (int c = 0; c < CHANNELS; c++) tile.pix[c] = tile_sums[c][SUM_W-1:SCALE_LOG2];
        tile.line_end = (col + 1 == full);
        expected_tiles.push_back(tile);
      end
    end
    // line wrap, also taken by a pixel past a lowered width
    if (col + 1 >= w) begin
      col_pos = 0;
      row_pos = (row_pos == ROW_FOURTH) ? ROW_FIRST : row_phase_e'(row_pos + 2'd1);
    end else begin
      col_pos = col + 1;
    end
  endtask

  task automatic note_error(input string msg);
    err_count++;
    if (err_count <= MAX_REPORTS) $display("ERROR: %s", msg);
  endtask

  // sender gap: mostly none or short, a few long
  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  function automatic int pick_stall();
    int r;
    r = $urandom_range(99);
    if (r < 80) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // offer one pixel item and wait until it is taken
  task automatic send_pixel(input pixel_t px, input bit fs);
    int gap;
    bit fs_eff;
    gap = pick_gap();
    if (gap > 0) begin
      pix_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    // restart the frame rather than read an unwritten store entry
    fs_eff = fs | reads_unset(fs);
    pix_valid <= 1'b1;
    pix_red   <= px[CH_RED];
    pix_green <= px[CH_GREEN];
    pix_blue  <= px[CH_BLUE];
    pix_fs    <= fs_eff;
    do @(posedge clk); while (!in_ready);
    advance_model(px, fs_eff);
    items_sent++;
  endtask

  // stop sending and wait for every expected tile, then let the pipe settle
  task automatic drain_tiles();
    int waited;
    waited = 0;
    pix_valid <= 1'b0;
    while (expected_tiles.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (expected_tiles.size() != 0) begin
      note_error($sformatf("%0d expected tiles never came out", expected_tiles.size()));
      expected_tiles.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_width(input logic [11:0] w);
    drain_tiles();
    width_we  <= 1'b1;
    width_val <= w;
    @(posedge clk);
    model_width = w;
    width_we <= 1'b0;
  endtask

  // default width after reset, then a lowered width cuts the line short
  task automatic test_default_width_overrun();
    send_pixel(mk_pixel(8'd0, 8'd255, 8'd0), 1'b1);
    for (int i = 1; i < 4; i++) send_pixel(mk_pixel(8'd0, 8'd255, 8'd0), 1'b0);
    set_width(12'd4);
    // column four is past the new width: dropped, ends the line
    send_pixel(mk_pixel(8'd7, 8'd7, 8'd7), 1'b0);
    for (int i = 0; i < 4; i++) send_pixel(mk_pixel(8'd255, 8'd255, 8'd1), 1'b0);
    for (int i = 0; i < 4; i++) send_pixel(mk_pixel(8'd1, 8'd0, 8'd255), 1'b0);
    for (int i = 0; i < 4; i++) send_pixel(mk_pixel(8'd0, 8'd0, 8'd254), 1'b0);
    drain_tiles();
  endtask

  // receiver holds off while the sender keeps offering items
  task automatic test_output_backpressure();
    set_width(12'd8);
    hold_reqs++;
    steady = 1'b1;
    for (int f = 0; f < 2; f++) begin
      for (int i = 0; i < 8 * SCALE; i++) send_pixel(rand_pixel(), i == 0);
    end
    steady = 1'b0;
    drain_tiles();
  endtask

  function automatic logic [11:0] pick_width();
    int r;
    r = $urandom_range(99);
    if (r < 70) return 12'(SCALE * $urandom_range(1, 5));
    if (r < 85) return 12'($urandom_range(5, 15));
    if (r < 93) return 12'($urandom_range(0, 3));
    case ($urandom_range(4))
      0:       return 12'd2048;
      1:       return 12'd4095;
      2:       return 12'd2047;
      3:       return 12'd2052;
      default: return 12'($urandom_range(2049, 4094));
    endcase
  endfunction

  // random widths and frames, with broken frames and mid-line stops
  task automatic test_random_frames();
    int first_item, frames, rows, extra;
    int unsigned ew;
    logic [11:0] w;
    bit fs;
    first_item = items_sent;
    while ((items_sent - first_item) < RANDOM_ITEMS) begin
      w = pick_width();
      set_width(w);
      ew = eff_width(w);
      steady = ($urandom_range(3) == 0);
      if (ew > 64) begin
        // wide lines: only the start of a frame, no tile row completes
        extra = $urandom_range(16, 40);
        for (int i = 0; i < extra; i++) send_pixel(rand_pixel(), i == 0);
      end else begin
        frames = $urandom_range(1, 2);
        for (int f = 0; f < frames; f++) begin
          rows = SCALE * $urandom_range(1, 3);
          for (int r = 0; r < rows; r++) begin
            for (int c = 0; c < ew; c++) begin
              fs = (r == 0 && c == 0) || ($urandom_range(199) == 0);
              send_pixel(rand_pixel(), fs);
            end
          end
        end
        // leave the line part way through, sometimes with stray frame starts
        if ($urandom_range(9) < 3) begin
          extra = $urandom_range(1, 6);
          for (int i = 0; i < extra; i++) send_pixel(rand_pixel(), $urandom_range(4) == 0);
        end
      end
      steady = 1'b0;
    end
    drain_tiles();
  endtask

  // receiver ready: random stalls except while steady, long hold on request
  int hold_seen = 0;
  int hold_left = 0;
  int stall_left = 0;
  always @(posedge clk) begin
    if (hold_reqs != hold_seen) begin
      hold_seen = hold_reqs;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      tile_ready <= 1'b0;
    end else if (steady) begin
      tile_ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      tile_ready <= 1'b0;
    end else if ($urandom_range(99) < 75) begin
      tile_ready <= 1'b1;
    end else begin
      stall_left = pick_stall() - 1;
      tile_ready <= 1'b0;
    end
  end

  // compare each output item with the oldest expected tile
  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_valid && tile_ready) begin
      if (expected_tiles.size() == 0) begin
        note_error($sformatf("unexpected tile r=%0d g=%0d b=%0d end=%0b",
                             out_red, out_green, out_blue, out_line_end));
      end else begin
        want = expected_tiles.pop_front();
        if (out_red !== want.pix[CH_RED] || out_green !== want.pix[CH_GREEN] ||
            out_blue !== want.pix[CH_BLUE] || out_line_end !== want.line_end) begin
          note_error($sformatf("tile exp r=%0d g=%0d b=%0d end=%0b got r=%0d g=%0d b=%0d end=%0b",
                               want.pix[CH_RED], want.pix[CH_GREEN], want.pix[CH_BLUE],
                               want.line_end, out_red, out_green, out_blue, out_line_end));
        end
      end
    end
  end

  // test sequence
  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_default_width_overrun();
    test_output_backpressure();
    test_random_frames();
    drain_tiles();
    if (err_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // run limit
  initial begin
    #(TIMEOUT_NS);
    $display("*** FAILED ***");
    $finish;
  end

endmodule
